// File: hdl/tlvps_pkg.sv
// Shared types and constants for the TLV parameter search block.
`default_nettype none

package tlvps_pkg;

   // Length byte value that announces a 16-bit big-endian length
   localparam logic [7:0] LEN_ESCAPE = 8'hff;

   // Command queue between parser and result expander (depth is a power of two)
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_TOO_LONG  = 2'd2,
      STATUS_TRUNCATED = 2'd3
   } status_type;

   // One parsed byte's worth of work: a value beat, a status beat, or both
   typedef struct packed {
      logic       has_value;
      logic       has_status;
      logic [7:0] value;
      status_type status;
   } cmd_type;

   // Queue head as seen by the expander
   typedef struct packed {
      logic    empty;
      cmd_type head;
   } queue_out_type;

endpackage : tlvps_pkg

`default_nettype wire

// File: hdl/tlvps_front.sv
// Byte parser: walks the TLV entries and issues value/status commands.
`default_nettype none

module tlvps_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       data_byte,
   input  wire logic             block_start,
   input  wire logic             block_end,
   input  wire logic [7:0]       want_type,
   input  wire logic [15:0]      max_len,
   output logic                  cmd_push,
   output tlvps_pkg::cmd_type    cmd
);
   import tlvps_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_TYPE  = 3'd1,
      PH_LEN   = 3'd2,
      PH_LENHI = 3'd3,
      PH_LENLO = 3'd4,
      PH_VALUE = 3'd5,
      PH_SKIP  = 3'd6,
      PH_DONE  = 3'd7
   } phase_type;

   phase_type   phase_ff, phase_in, phase_cur;
   logic [7:0]  target_ff, target_in, target_cur;
   logic [15:0] limit_ff, limit_in, limit_cur;
   logic        matches_ff, matches_in, matches_cur;
   logic [15:0] len_ff, len_in, len_cur;
   logic [15:0] known_len;
   logic [15:0] len_dec;
   logic        len_complete;

   always_comb begin
      // A block start restarts the search on this very byte
      phase_cur   = block_start ? PH_TYPE : phase_ff;
      target_cur  = block_start ? want_type : target_ff;
      limit_cur   = block_start ? max_len : limit_ff;
      matches_cur = block_start ? 1'b0 : matches_ff;
      len_cur     = block_start ? 16'd0 : len_ff;

      known_len = (phase_cur == PH_LEN) ? {8'h00, data_byte} : {len_cur[15:8], data_byte};
      len_dec   = len_cur - 16'd1;
      len_complete = 1'b0;

      phase_in   = phase_cur;
      target_in  = target_cur;
      limit_in   = limit_cur;
      matches_in = matches_cur;
      len_in     = len_cur;

      cmd.has_value  = 1'b0;
      cmd.has_status = 1'b0;
      cmd.value      = data_byte;
      cmd.status     = STATUS_FOUND;

      case (phase_cur)
         PH_TYPE: begin
            matches_in = (data_byte == target_cur);
            phase_in   = PH_LEN;
            if (block_end) begin
               cmd.has_status = 1'b1;
               cmd.status     = (data_byte == target_cur) ? STATUS_TRUNCATED
                                                          : STATUS_NOT_FOUND;
               phase_in       = PH_DONE;
            end
         end
         PH_LEN: begin
            if (data_byte == LEN_ESCAPE) begin
               phase_in = PH_LENHI;
               if (block_end) begin
                  cmd.has_status = 1'b1;
                  cmd.status     = matches_cur ? STATUS_TRUNCATED : STATUS_NOT_FOUND;
                  phase_in       = PH_DONE;
               end
            end else begin
               len_complete = 1'b1;
            end
         end
         PH_LENHI: begin
            len_in   = {data_byte, 8'h00};
            phase_in = PH_LENLO;
            if (block_end) begin
               cmd.has_status = 1'b1;
               cmd.status     = matches_cur ? STATUS_TRUNCATED : STATUS_NOT_FOUND;
               phase_in       = PH_DONE;
            end
         end
         PH_LENLO: begin
            len_complete = 1'b1;
         end
         PH_VALUE: begin
            cmd.has_value = 1'b1;
            len_in        = len_dec;
            if (len_dec == 16'd0) begin
               cmd.has_status = 1'b1;
               cmd.status     = STATUS_FOUND;
               phase_in       = PH_DONE;
            end else if (block_end) begin
               cmd.has_status = 1'b1;
               cmd.status     = STATUS_TRUNCATED;
               phase_in       = PH_DONE;
            end
         end
         PH_SKIP: begin
            len_in = len_dec;
            if (block_end) begin
               cmd.has_status = 1'b1;
               cmd.status     = STATUS_NOT_FOUND;
               phase_in       = PH_DONE;
            end else if (len_dec == 16'd0) begin
               phase_in = PH_TYPE;
            end
         end
         default: begin
         end
      endcase

      // Entry header complete: check a matched length against the limit, or skip the entry
      if (len_complete) begin
         if (matches_cur) begin
            if (known_len > limit_cur) begin
               cmd.has_status = 1'b1;
               cmd.status     = STATUS_TOO_LONG;
               phase_in       = PH_DONE;
            end else if (known_len == 16'd0) begin
               cmd.has_status = 1'b1;
               cmd.status     = STATUS_FOUND;
               phase_in       = PH_DONE;
            end else begin
               len_in = known_len;
               if (block_end) begin
                  cmd.has_status = 1'b1;
                  cmd.status     = STATUS_TRUNCATED;
                  phase_in       = PH_DONE;
               end else begin
                  phase_in = PH_VALUE;
               end
            end
         end else begin
            len_in = known_len;
            if (block_end) begin
               cmd.has_status = 1'b1;
               cmd.status     = STATUS_NOT_FOUND;
               phase_in       = PH_DONE;
            end else begin
               phase_in = (known_len == 16'd0) ? PH_TYPE : PH_SKIP;
            end
         end
      end

      cmd_push = accept && (cmd.has_value || cmd.has_status);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
      if (accept) begin
         target_ff  <= target_in;
         limit_ff   <= limit_in;
         matches_ff <= matches_in;
         len_ff     <= len_in;
      end
   end

`ifndef ASSERT_OFF
   // Any status ends the search until the next block start
   a_status_ends_search: assert property (@(posedge clock) disable iff (reset)
      cmd_push && cmd.has_status && !(accept && block_start) |=> phase_ff == PH_DONE)
      else $error("parser kept going after a final status");

   // Value beats, and so two results per byte, come only from the value phase
   a_pair_only_from_value: assert property (@(posedge clock) disable iff (reset)
      cmd_push && cmd.has_value |-> phase_cur == PH_VALUE)
      else $error("value beat issued outside the value phase");
`endif

endmodule : tlvps_front

`default_nettype wire

// File: hdl/tlvps_queue.sv
// Short command queue between the parser and the result expander.
`default_nettype none

module tlvps_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire tlvps_pkg::cmd_type   push_cmd,
   input  wire logic                 pop,
   output logic                      full,
   output tlvps_pkg::queue_out_type  q_out
);
   import tlvps_pkg::*;

   cmd_type                      entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         do_push, do_pop;

   always_comb begin
      full        = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
      q_out.empty = (count_ff == '0);
      q_out.head  = entries_ff[rd_ptr_ff];
      do_push     = push && !full;
      do_pop      = pop && !q_out.empty;
      wr_ptr_in   = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in   = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in    = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("command queue count out of range");
`endif

endmodule : tlvps_queue

`default_nettype wire

// File: hdl/tlvps_back.sv
// Result expander: turns each queued command into one or two result beats.
`default_nettype none

module tlvps_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tlvps_pkg::queue_out_type  q_out,
   output logic                           q_pop,
   input  wire logic                      pop,
   output logic                           empty,
   output logic                           result_kind,
   output logic [7:0]                     value_byte,
   output tlvps_pkg::status_type          status,
   output logic                           last_of_run
);
   import tlvps_pkg::*;

   // Value beat of a two-beat command already delivered
   logic value_sent_ff, value_sent_in;
   logic show_value;

   always_comb begin
      empty      = q_out.empty;
      show_value = q_out.head.has_value && !value_sent_ff;
      if (show_value) begin
         result_kind = KIND_VALUE;
         value_byte  = q_out.head.value;
         status      = STATUS_FOUND;
         last_of_run = !q_out.head.has_status;
      end else begin
         result_kind = KIND_STATUS;
         value_byte  = 8'h00;
         status      = q_out.head.status;
         last_of_run = 1'b1;
      end
      // Retire the command on its final beat
      q_pop         = pop && !q_out.empty && last_of_run;
      value_sent_in = value_sent_ff;
      if (pop && !q_out.empty) begin
         value_sent_in = !last_of_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_sent_ff <= 1'b0;
      end else begin
         value_sent_ff <= value_sent_in;
      end
   end

`ifndef ASSERT_OFF
   a_split_needs_pair: assert property (@(posedge clock) disable iff (reset)
      value_sent_ff |-> !q_out.empty && q_out.head.has_value && q_out.head.has_status)
      else $error("half-delivered command lost its status beat");
`endif

endmodule : tlvps_back

`default_nettype wire

// File: hdl/tlv_parameter_search.sv
// Top level of the TLV parameter search: parser, command queue, result expander.
//
//  channel  direction  handshake     beat contents
//  req      in         push / full   data byte, block start/end, wanted type, max length
//  rsp      out        pop / empty   result kind, value byte, status, last of run
//
// One input byte is taken per cycle while the 4-entry command queue has room.
// Each byte gives zero, one or two result beats; the expander delivers one beat
// per cycle while pop is high, so a value byte that ends its value or block gives two.
// Results are registered in the command queue and reach the rsp ports from its head.
// Synchronous reset empties the queue and returns the parser to idle.
// A stalled rsp side backs up into the queue and then raises full.
`default_nettype none

module tlv_parameter_search (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_block_start,
   input  wire logic        req_block_end,
   input  wire logic [7:0]  req_want_type,
   input  wire logic [15:0] req_max_len,
   output logic             empty,
   input  wire logic        pop,
   output logic             rsp_result_kind,
   output logic [7:0]       rsp_value_byte,
   output logic [1:0]       rsp_status,
   output logic             rsp_last_of_run
);
   import tlvps_pkg::*;

   logic          accept;
   logic          cmd_push;
   cmd_type       cmd;
   logic          q_pop;
   queue_out_type q_out;
   status_type    status;

   assign accept     = push && !full;
   assign rsp_status = status;

   tlvps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .block_start (req_block_start),
      .block_end   (req_block_end),
      .want_type   (req_want_type),
      .max_len     (req_max_len),
      .cmd_push    (cmd_push),
      .cmd         (cmd)
   );

   tlvps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .full     (full),
      .q_out    (q_out)
   );

   tlvps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_out       (q_out),
      .q_pop       (q_pop),
      .pop         (pop),
      .empty       (empty),
      .result_kind (rsp_result_kind),
      .value_byte  (rsp_value_byte),
      .status      (status),
      .last_of_run (rsp_last_of_run)
   );

endmodule : tlv_parameter_search

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking bench for tlv_parameter_search: block stream in, value and status beats out.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tlvps_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_BYTES = 1850;

   typedef enum logic [2:0] {
      PH_IDLE, PH_TYPE, PH_LEN, PH_LENHI, PH_LENLO, PH_VALUE, PH_SKIP, PH_DONE
   } scan_phase_t;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      status_type status;
      logic       last_of_run;
   } rsp_beat_t;

   typedef struct {
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [7:0]  want;
      logic [15:0] limit;
      bit          drain;
   } tlv_byte_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic [7:0]  req_data_byte = '0;
   logic        req_block_start = 1'b0;
   logic        req_block_end = 1'b0;
   logic [7:0]  req_want_type = '0;
   logic [15:0] req_max_len = '0;
   logic        full, empty;
   logic        rsp_result_kind, rsp_last_of_run;
   logic [7:0]  rsp_value_byte;
   logic [1:0]  rsp_status;

   tlv_parameter_search dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_data_byte   (req_data_byte),
      .req_block_start (req_block_start),
      .req_block_end   (req_block_end),
      .req_want_type   (req_want_type),
      .req_max_len     (req_max_len),
      .empty           (empty),
      .pop             (pop),
      .rsp_result_kind (rsp_result_kind),
      .rsp_value_byte  (rsp_value_byte),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   tlv_byte_t tlv_bytes [$];
   rsp_beat_t tlv_results [$];
   int        tlv_bytes_total = 0;
   int        stim_count = 0;
   bit        drain_next = 1'b0;
   int        taken_count = 0;
   int        fail_count = 0;
   int        stall_cycles = 0;
   bit        req_taken = 1'b0;
   int        hold_left = 0;
   bit        hold_done = 1'b0;

   // search state
   scan_phase_t scan_phase = PH_IDLE;
   logic [15:0] bytes_left = '0;
   logic [7:0]  target_type = '0;
   logic [15:0] len_limit = '0;
   logic        type_hit = 1'b0;

   function automatic bit no_idle_zone();
      return taken_count >= 900 && taken_count < 1200;
   endfunction

   function automatic rsp_beat_t status_beat(input status_type s);
      return rsp_beat_t'({KIND_STATUS, 8'h00, s, 1'b0});
   endfunction

   // block ended before the entry header was complete
   function automatic rsp_beat_t header_cut();
      scan_phase = PH_DONE;
      return status_beat(type_hit ? STATUS_TRUNCATED : STATUS_NOT_FOUND);
   endfunction

   function automatic int length_done(input logic [15:0] len, input logic last,
                                      output rsp_beat_t beat);
      beat = '0;
      if (type_hit) begin
         if (len > len_limit) begin
            scan_phase = PH_DONE;
            beat = status_beat(STATUS_TOO_LONG);
            return 1;
         end
         if (len == 16'h0000) begin
            scan_phase = PH_DONE;
            beat = status_beat(STATUS_FOUND);
            return 1;
         end
         bytes_left = len;
         if (last) begin
            scan_phase = PH_DONE;
            beat = status_beat(STATUS_TRUNCATED);
            return 1;
         end
         scan_phase = PH_VALUE;
         return 0;
      end
      bytes_left = len;
      if (last) begin
         scan_phase = PH_DONE;
         beat = status_beat(STATUS_NOT_FOUND);
         return 1;
      end
      scan_phase = (len == 16'h0000) ? PH_TYPE : PH_SKIP;
      return 0;
   endfunction

   function automatic void search_step(input logic [7:0] b, input logic first,
                                       input logic last, input logic [7:0] want,
                                       input logic [15:0] limit);
      rsp_beat_t beats [2];
      int        n;
      n = 0;
      beats[0] = '0;
      beats[1] = '0;
      if (first) begin
         target_type = want;
         len_limit = limit;
         type_hit = 1'b0;
         bytes_left = '0;
         scan_phase = PH_TYPE;
      end
      case (scan_phase)
         PH_TYPE: begin
            type_hit = (b == target_type);
            scan_phase = PH_LEN;
            if (last) begin
               beats[0] = header_cut();
               n = 1;
            end
         end
         PH_LEN: begin
            if (b == LEN_ESCAPE) begin
               scan_phase = PH_LENHI;
               if (last) begin
                  beats[0] = header_cut();
                  n = 1;
               end
            end else begin
               n = length_done({8'h00, b}, last, beats[0]);
            end
         end
         PH_LENHI: begin
            bytes_left = {b, 8'h00};
            scan_phase = PH_LENLO;
            if (last) begin
               beats[0] = header_cut();
               n = 1;
            end
         end
         PH_LENLO: begin
            n = length_done(bytes_left | {8'h00, b}, last, beats[0]);
         end
         PH_VALUE: begin
            beats[0] = rsp_beat_t'({KIND_VALUE, b, STATUS_FOUND, 1'b0});
            n = 1;
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'h0000) begin
               beats[1] = status_beat(STATUS_FOUND);
               scan_phase = PH_DONE;
               n = 2;
            end else if (last) begin
               beats[1] = status_beat(STATUS_TRUNCATED);
               scan_phase = PH_DONE;
               n = 2;
            end
         end
         PH_SKIP: begin
            bytes_left = bytes_left - 16'd1;
            if (last) begin
               beats[0] = status_beat(STATUS_NOT_FOUND);
               scan_phase = PH_DONE;
               n = 1;
            end else if (bytes_left == 16'h0000) begin
               scan_phase = PH_TYPE;
            end
         end
         default: ;
      endcase
      if (n > 0) beats[n - 1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) tlv_results.push_back(beats[i]);
   endfunction

   function automatic void queue_byte(input logic [7:0] data, input logic first,
                                      input logic last, input logic [7:0] want,
                                      input logic [15:0] limit);
      tlv_byte_t item;
      item.data = data;
      item.first = first;
      item.last = last;
      item.want = want;
      item.limit = limit;
      item.drain = drain_next;
      drain_next = 1'b0;
      tlv_bytes.push_back(item);
   endfunction

   // well-formed block with random entries, sometimes cut short or left open
   function automatic void queue_random_block();
      logic [7:0]  want;
      logic [15:0] limit;
      logic [15:0] len;
      logic [7:0]  body [$];
      int          entries, pick, keep, end_at;
      bit          long_cut;
      want = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 10) limit = 16'h0000;
      else if (pick < 20) limit = 16'hffff;
      else if (pick < 60) limit = 16'($urandom_range(10));
      else limit = 16'($urandom_range(65535));
      entries = $urandom_range(1, 4);
      long_cut = 1'b0;
      for (int e = 0; e < entries && !long_cut; e++) begin
         body.push_back(($urandom_range(99) < 45) ? want : 8'($urandom_range(255)));
         pick = $urandom_range(99);
         if (pick < 60) len = 16'($urandom_range(8));
         else if (pick < 70) len = 16'($urandom_range(254, 9));
         else if (pick < 85) len = 16'($urandom_range(12));
         else len = 16'($urandom_range(65535));
         if (pick < 70) begin
            body.push_back(len[7:0]);
         end else begin
            body.push_back(LEN_ESCAPE);
            body.push_back(len[15:8]);
            body.push_back(len[7:0]);
         end
         keep = int'(len);
         // long value: send only its head and end the block there
         if (len > 16'd24) begin
            keep = $urandom_range(6);
            long_cut = 1'b1;
         end
         repeat (keep) body.push_back(8'($urandom_range(255)));
      end
      end_at = body.size() - 1;
      pick = $urandom_range(99);
      if (pick < 12) begin
         end_at = $urandom_range(body.size() - 1);
         while (body.size() > end_at + 1) void'(body.pop_back());
      end else if (pick < 17) begin
         end_at = -1;
      end
      for (int i = 0; i < body.size(); i++)
         queue_byte(body[i], i == 0, i == end_at,
                    (i == 0) ? want : 8'($urandom_range(255)),
                    (i == 0) ? limit : 16'($urandom_range(65535)));
      stim_count += body.size();
      if ($urandom_range(99) < 20)
         repeat ($urandom_range(3, 1))
            queue_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                       8'($urandom_range(255)), 16'($urandom_range(65535)));
   endfunction

   // driver: hold a beat until taken, then offer the next one or idle
   always @(negedge clock) begin
      tlv_byte_t item;
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_taken) begin
         req_taken = 1'b0;
         if (tlv_bytes.size() > 0 && (!tlv_bytes[0].drain || tlv_results.size() == 0) &&
             (no_idle_zone() || $urandom_range(99) >= 17)) begin
            item = tlv_bytes.pop_front();
            push <= 1'b1;
            req_data_byte <= item.data;
            req_block_start <= item.first;
            req_block_end <= item.last;
            req_want_type <= item.want;
            req_max_len <= item.limit;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver: random pops, plus one long hold-off to back up the queue
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else if (!hold_done && taken_count >= 400) begin
         hold_done = 1'b1;
         hold_left = 120;
         pop <= 1'b0;
      end else begin
         pop <= no_idle_zone() || $urandom_range(99) >= 17;
      end
   end

   // monitor: check result beats, predict on input beats, watch for a hang
   always @(posedge clock) begin
      rsp_beat_t seen, owed;
      if (reset) begin
         scan_phase = PH_IDLE;
         bytes_left = '0;
         target_type = '0;
         len_limit = '0;
         type_hit = 1'b0;
         stall_cycles = 0;
      end else begin
         if (pop && !empty) begin
            seen = rsp_beat_t'({rsp_result_kind, rsp_value_byte, rsp_status, rsp_last_of_run});
            if (tlv_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat: kind %0d value %02h status %0d last %0d",
                        $time, seen.kind, seen.value, seen.status, seen.last_of_run);
            end else begin
               owed = tlv_results.pop_front();
               if (seen !== owed) begin
                  fail_count++;
                  $display("%0t: result mismatch: expected kind %0d value %02h status %0d last %0d",
                           $time, owed.kind, owed.value, owed.status, owed.last_of_run);
                  $display("%0t:                  actual kind %0d value %02h status %0d last %0d",
                           $time, seen.kind, seen.value, seen.status, seen.last_of_run);
               end
            end
         end
         if (push && !full) begin
            search_step(req_data_byte, req_block_start, req_block_end, req_want_type,
                        req_max_len);
            taken_count++;
            req_taken = 1'b1;
         end
         if ((pop && !empty) || (push && !full)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      int next_drain;
      // ignored before any block
      queue_byte(8'hff, 1'b0, 1'b1, 8'hff, 16'hffff);
      // one-byte match ending on the block end: value, then found
      queue_byte(8'hff, 1'b1, 1'b0, 8'hff, 16'hffff);
      queue_byte(8'h01, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'hff, 1'b0, 1'b1, 8'h00, 16'h0000);
      // zero-length match, then a byte after the decision
      queue_byte(8'h00, 1'b1, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'h00, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'h5a, 1'b0, 1'b0, 8'h00, 16'h0000);
      // empty skipped entry, then escaped length over the limit
      queue_byte(8'h11, 1'b1, 1'b0, 8'h5a, 16'h0003);
      queue_byte(8'h00, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'h5a, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(LEN_ESCAPE, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'h00, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'h04, 1'b0, 1'b0, 8'h00, 16'h0000);
      // block ends inside a matched value
      queue_byte(8'h33, 1'b1, 1'b0, 8'h33, 16'hffff);
      queue_byte(8'h03, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'haa, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'hbb, 1'b0, 1'b1, 8'h00, 16'h0000);
      // block ends inside a matched header
      queue_byte(8'h77, 1'b1, 1'b0, 8'h77, 16'h0010);
      queue_byte(LEN_ESCAPE, 1'b0, 1'b1, 8'h00, 16'h0000);
      // block ends on a non-matching type byte
      queue_byte(8'h01, 1'b1, 1'b1, 8'h02, 16'h0010);
      // restart mid-value; zero-length match decided on the last byte
      queue_byte(8'h10, 1'b1, 1'b0, 8'h10, 16'h0008);
      queue_byte(8'h05, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'h01, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'h20, 1'b1, 1'b0, 8'h20, 16'h0000);
      queue_byte(8'h00, 1'b0, 1'b1, 8'h00, 16'h0000);
      // block ends on the last byte of a skipped entry
      queue_byte(8'h41, 1'b1, 1'b0, 8'h40, 16'h0008);
      queue_byte(8'h02, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'h12, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'h34, 1'b0, 1'b1, 8'h00, 16'h0000);

      // drain everything before the random part and every 500 bytes after
      next_drain = 0;
      while (stim_count < RANDOM_BYTES) begin
         if (stim_count >= next_drain) begin
            drain_next = 1'b1;
            next_drain += 500;
         end
         if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(8, 1)) begin
               queue_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
                          $urandom_range(3) == 0, 8'($urandom_range(255)),
                          16'($urandom_range(65535)));
               stim_count++;
            end
         end else begin
            queue_random_block();
         end
      end
      tlv_bytes_total = tlv_bytes.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (taken_count < tlv_bytes_total) @(negedge clock);
      while (tlv_results.size() > 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (fail_count == 0 && tlv_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
